@@ hdl/cifu_pkg.sv @@
// Shared constants, register codes and angle table for the IMU complementary filter.
package cifu_pkg;

    // field and datapath widths
    localparam int IN_W      = 16;
    localparam int DT_W      = 20;
    localparam int US_W      = 17;
    localparam int ANG_W     = 23;
    localparam int ACC_W     = 24;
    localparam int XW        = 36;
    localparam int MUL_AW    = 26;
    localparam int MUL_BW    = 17;
    localparam int MUL_PW    = 43;
    localparam int SQ_IN_W   = 60;
    localparam int SQ_ROOT_W = 30;
    localparam int SAT_W     = 27;
    localparam int CFG_IDX_W = 2;

    // elapsed time clamp in microseconds
    localparam int DT_MAX_US = 100000;

    // gyro scale divisor 2^11 * 10^6 and its half for rounding
    localparam logic [30:0] GYRO_DIV  = 31'd2048000000;
    localparam logic [30:0] GYRO_HALF = 31'd1024000000;

    // pi with 20 fraction bits
    localparam int PI20 = 3294199;

    // angle saturation limits
    localparam logic signed [ANG_W-1:0] ANG_MAX = 23'sh3FFFFF;
    localparam logic signed [ANG_W-1:0] ANG_MIN = 23'sh400000;

    // register reset value
    localparam logic [15:0] GAIN_RESET = 16'd62915;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFF   = 2'd2;

    typedef logic signed [ACC_W-1:0] angle_t;

    // round a 20-fraction-bit angle down to frac fraction bits
    function automatic angle_t from20(input int t, input int frac);
        int s;
        int r;
        s = 20 - frac;
        if (s == 0)
            r = t;
        else
            r = ((t >>> (s - 1)) + 1) >>> 1;
        return ACC_W'(r);
    endfunction

    // arctangent of 2^-i, rounded to frac fraction bits
    function automatic angle_t atan_lut(input logic [4:0] i, input int frac);
        int t;
        case (i)
            5'd0:    t = 823550;
            5'd1:    t = 486170;
            5'd2:    t = 256879;
            5'd3:    t = 130396;
            5'd4:    t = 65451;
            5'd5:    t = 32757;
            5'd6:    t = 16383;
            5'd7:    t = 8192;
            5'd8:    t = 4096;
            5'd9:    t = 2048;
            5'd10:   t = 1024;
            5'd11:   t = 512;
            5'd12:   t = 256;
            5'd13:   t = 128;
            5'd14:   t = 64;
            5'd15:   t = 32;
            5'd16:   t = 16;
            5'd17:   t = 8;
            5'd18:   t = 4;
            5'd19:   t = 2;
            5'd20:   t = 1;
            default: t = 0;
        endcase
        return from20(t, frac);
    endfunction

endpackage

@@ hdl/cifu_cordic.sv @@
// Iterative vectoring CORDIC computing atan2(y, x), one rotation per cycle.
module cifu_cordic #(
    parameter int STEPS = 16,
    parameter int FRAC  = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [cifu_pkg::XW-1:0]   y_in,
    input  logic signed [cifu_pkg::XW-1:0]   x_in,
    output logic signed [cifu_pkg::ACC_W-1:0] z_out,
    output logic                             done
);
    import cifu_pkg::*;

    localparam int CW = $clog2(STEPS);
    localparam logic [CW-1:0] LAST = CW'(STEPS - 1);
    localparam angle_t PI_A = from20(PI20, FRAC);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic signed [XW-1:0]    x_reg, x_next, y_reg, y_next;
    angle_t                  z_reg, z_next;
    logic signed [XW-1:0]    dx, dy;
    angle_t                  a;

    // one micro-rotation toward the x axis
    always_comb
    begin
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        a = atan_lut(5'(cnt_reg), FRAC);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (start)
        begin
            cnt_next = '0;
            if (y_in == 0)
            begin
                z_next = (x_in < 0) ? PI_A : '0;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else if (x_in < 0)
            begin
                x_next = -x_in;
                y_next = -y_in;
                z_next = (y_in > 0) ? PI_A : -PI_A;
                busy_next = 1'b1;
            end
            else
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + a;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - a;
            end
            cnt_next = CW'(cnt_reg + 1'b1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign z_out = z_reg;
    assign done = done_reg;

endmodule

@@ hdl/cifu_isqrt.sv @@
// Bit-serial floor square root, one root bit per cycle.
module cifu_isqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [cifu_pkg::SQ_IN_W-1:0]     n_in,
    output logic [cifu_pkg::SQ_ROOT_W-1:0]   root,
    output logic                             done
);
    import cifu_pkg::*;

    localparam logic [4:0] LAST = 5'(SQ_ROOT_W - 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic [SQ_IN_W-1:0]      n_reg, n_next;
    logic [32:0]             rem_reg, rem_next;
    logic [SQ_ROOT_W-1:0]    root_reg, root_next;
    logic [32:0]             r2, trial;

    // bring down two radicand bits and try the next root bit
    always_comb
    begin
        r2 = {rem_reg[30:0], n_reg[SQ_IN_W-1 -: 2]};
        trial = {1'b0, root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        n_next = n_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            n_next = n_in;
            rem_next = '0;
            root_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[SQ_IN_W-3:0], 2'b00};
            if (r2 >= trial)
            begin
                rem_next = r2 - trial;
                root_next = {root_reg[SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = r2;
                root_next = {root_reg[SQ_ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            n_reg <= '0;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            n_reg <= n_next;
            rem_reg <= rem_next;
            root_reg <= root_next;
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

@@ hdl/cifu_mul.sv @@
// Serial shift-add multiplier: signed multiplicand, unsigned multiplier, one bit per cycle.
module cifu_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [cifu_pkg::MUL_AW-1:0] a_in,
    input  logic [cifu_pkg::MUL_BW-1:0]        b_in,
    output logic signed [cifu_pkg::MUL_PW-1:0] p_out,
    output logic                               done
);
    import cifu_pkg::*;

    localparam logic [4:0] LAST = 5'(MUL_BW - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic signed [MUL_PW-1:0] a_reg, a_next, p_reg, p_next;
    logic [MUL_BW-1:0]        b_reg, b_next;

    // add the shifted multiplicand for each set multiplier bit
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        a_next = a_reg;
        b_next = b_reg;
        p_next = p_reg;
        if (start)
        begin
            a_next = MUL_PW'(a_in);
            b_next = b_in;
            p_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                p_next = p_reg + a_reg;
            a_next = a_reg <<< 1;
            b_next = b_reg >> 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
            p_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            a_reg <= a_next;
            b_reg <= b_next;
            p_reg <= p_next;
        end
    end

    assign p_out = p_reg;
    assign done = done_reg;

endmodule

@@ hdl/cifu_div.sv @@
// Restoring divider by the gyro scale constant, one quotient bit per cycle.
module cifu_div #(
    parameter int FRAC = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [FRAC+33:0]    n_in,
    output logic [FRAC+1:0]     q_out,
    output logic                done
);
    import cifu_pkg::*;

    localparam int NW = FRAC + 34;
    localparam int QW = FRAC + 2;
    localparam int CW = $clog2(QW);
    localparam logic [CW-1:0] LAST = CW'(QW - 1);
    localparam logic [32:0] DIVISOR = 33'(GYRO_DIV);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [31:0]       rem_reg, rem_next;
    logic [QW-1:0]     lo_reg, lo_next;
    logic [32:0]       t;
    logic              ge;

    // shift in one dividend bit and subtract where it fits
    always_comb
    begin
        t = {rem_reg, lo_reg[QW-1]};
        ge = (t >= DIVISOR);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        lo_next = lo_reg;
        if (start)
        begin
            rem_next = n_in[NW-1:QW];
            lo_next = n_in[QW-1:0];
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(t - DIVISOR) : t[31:0];
            lo_next = {lo_reg[QW-2:0], ge};
            cnt_next = CW'(cnt_reg + 1'b1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            rem_reg <= '0;
            lo_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
            lo_reg <= lo_next;
        end
    end

    assign q_out = lo_reg;
    assign done = done_reg;

endmodule

@@ hdl/imu_complementary_filter_unit.sv @@
// Top level of the roll/pitch complementary filter with its sequencer.
//
//  channel | signals                                   | direction | word
//  --------+-------------------------------------------+-----------+--------------------------
//  in      | in_valid, in_ready                        | into unit | accel xyz, rates, dt, seed
//  out     | out_valid, out_ready                      | out       | roll_angle, pitch_angle
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into unit | one register write
//
// One word at a time. A normal word runs the serial multiplier, square root, divider and
// CORDIC back to back; an angle whose y input is zero skips its CORDIC_STEPS rotations.
// A seeded word runs only the roll CORDIC, loads the roll estimate from it and goes
// straight to the output register.
// Reset clears both kept angles and loads the register defaults.
// A finished word waits in the output register; a new input word is taken meanwhile
// and the next result is held until that register is free. cfg writes are always taken.
module imu_complementary_filter_unit #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [15:0]                   accel_x,
    input  logic signed [15:0]                   accel_y,
    input  logic signed [15:0]                   accel_z,
    input  logic signed [15:0]                   rate_roll,
    input  logic signed [15:0]                   rate_pitch,
    input  logic [19:0]                          elapsed_us,
    input  logic                                 seed,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [22:0]                   roll_angle,
    output logic signed [22:0]                   pitch_angle,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cifu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                          cfg_data
);
    import cifu_pkg::*;

    localparam int DIV_NW = ANGLE_FRAC_BITS + 34;
    localparam int DIV_QW = ANGLE_FRAC_BITS + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_RACC, S_SQA, S_SQB, S_ROOT, S_PACC, S_RMUL, S_RDIV,
        S_RBLEND, S_PMUL, S_PDIV, S_PBLEND, S_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic                     go_reg, go_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [ANG_W-1:0]  roll_out_reg, roll_out_next;
    logic signed [ANG_W-1:0]  pitch_out_reg, pitch_out_next;
    logic [15:0]              gain_reg, gain_next;
    logic signed [15:0]       roll_off_reg, roll_off_next;
    logic signed [15:0]       pitch_off_reg, pitch_off_next;
    logic signed [ANG_W-1:0]  roll_est_reg, roll_est_next;
    logic signed [ANG_W-1:0]  pitch_est_reg, pitch_est_next;
    logic signed [15:0]       ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [15:0]       wr_reg, wr_next, wp_reg, wp_next;
    logic [US_W-1:0]          us_reg, us_next;
    logic                     seed_reg, seed_next;
    logic [31:0]              mag2_reg, mag2_next;
    angle_t                   roll_tilt_reg, roll_tilt_next;
    angle_t                   pitch_tilt_reg, pitch_tilt_next;
    logic                     neg_reg, neg_next;
    logic [33:0]              mag_reg, mag_next;
    logic signed [24:0]       diff_reg, diff_next;

    // arithmetic unit ports
    logic                     cordic_start, cordic_done;
    logic signed [XW-1:0]     cordic_y, cordic_x;
    angle_t                   cordic_z;
    logic                     sqrt_start, sqrt_done;
    logic [SQ_ROOT_W-1:0]     sqrt_root;
    logic                     mul_start, mul_done;
    logic signed [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0]        mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    logic                     div_start, div_done;
    logic [DIV_NW-1:0]        div_n;
    logic [DIV_QW-1:0]        div_q;

    // datapath helpers
    logic signed [16:0]       ay_ext, az_ext, m_roll, m_pitch;
    logic [16:0]              ay_abs, az_abs;
    logic signed [MUL_PW-1:0] p_abs, mix;
    angle_t                   step, gyro, acc_sel;
    logic signed [ANG_W-1:0]  est_sel, blended;

    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [SAT_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > SAT_W'(ANG_MAX))
            r = ANG_MAX;
        else if (v < SAT_W'(ANG_MIN))
            r = ANG_MIN;
        else
            r = v[ANG_W-1:0];
        return r;
    endfunction

    cifu_cordic #(.STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cordic_start),
        .y_in(cordic_y), .x_in(cordic_x), .z_out(cordic_z), .done(cordic_done)
    );

    cifu_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start),
        .n_in({mag2_reg, 28'd0}), .root(sqrt_root), .done(sqrt_done)
    );

    cifu_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a_in(mul_a), .b_in(mul_b), .p_out(mul_p), .done(mul_done)
    );

    cifu_div #(.FRAC(ANGLE_FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .n_in(div_n), .q_out(div_q), .done(div_done)
    );

    // unit starts and operand selection
    always_comb
    begin
        cordic_start = go_reg && (state_reg == S_RACC || state_reg == S_PACC);
        sqrt_start = go_reg && (state_reg == S_ROOT);
        div_start = go_reg && (state_reg == S_RDIV || state_reg == S_PDIV);
        mul_start = go_reg && (state_reg == S_SQA || state_reg == S_SQB ||
                               state_reg == S_RMUL || state_reg == S_PMUL ||
                               state_reg == S_RBLEND || state_reg == S_PBLEND);

        if (state_reg == S_PACC)
        begin
            cordic_y = -(XW'(ax_reg) <<< 14);
            cordic_x = XW'(sqrt_root);
        end
        else
        begin
            cordic_y = XW'(ay_reg) <<< 14;
            cordic_x = XW'(az_reg) <<< 14;
        end

        ay_ext = 17'(ay_reg);
        az_ext = 17'(az_reg);
        ay_abs = ay_ext[16] ? 17'(-ay_ext) : 17'(ay_ext);
        az_abs = az_ext[16] ? 17'(-az_ext) : 17'(az_ext);
        m_roll = 17'(wr_reg) - 17'(roll_off_reg);
        m_pitch = 17'(wp_reg) - 17'(pitch_off_reg);

        case (state_reg)
            S_SQA:
            begin
                mul_a = {9'd0, ay_abs};
                mul_b = ay_abs;
            end
            S_SQB:
            begin
                mul_a = {9'd0, az_abs};
                mul_b = az_abs;
            end
            S_RMUL:
            begin
                mul_a = MUL_AW'(m_roll);
                mul_b = us_reg;
            end
            S_PMUL:
            begin
                mul_a = MUL_AW'(m_pitch);
                mul_b = us_reg;
            end
            S_RBLEND, S_PBLEND:
            begin
                mul_a = MUL_AW'(diff_reg);
                mul_b = {1'b0, gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        div_n = (DIV_NW'(mag_reg) << ANGLE_FRAC_BITS) + DIV_NW'(GYRO_HALF);
    end

    // sequencer and register file
    always_comb
    begin
        state_next = state_reg;
        go_next = 1'b0;
        out_valid_next = out_valid_reg;
        roll_out_next = roll_out_reg;
        pitch_out_next = pitch_out_reg;
        gain_next = gain_reg;
        roll_off_next = roll_off_reg;
        pitch_off_next = pitch_off_reg;
        roll_est_next = roll_est_reg;
        pitch_est_next = pitch_est_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        az_next = az_reg;
        wr_next = wr_reg;
        wp_next = wp_reg;
        us_next = us_reg;
        seed_next = seed_reg;
        mag2_next = mag2_reg;
        roll_tilt_next = roll_tilt_reg;
        pitch_tilt_next = pitch_tilt_reg;
        neg_next = neg_reg;
        mag_next = mag_reg;
        diff_next = diff_reg;

        p_abs = mul_p[MUL_PW-1] ? -mul_p : mul_p;
        step = ACC_W'(div_q);
        if (neg_reg)
            step = -step;
        est_sel = (state_reg == S_RDIV || state_reg == S_RBLEND) ? roll_est_reg
                                                                 : pitch_est_reg;
        acc_sel = (state_reg == S_RDIV || state_reg == S_RBLEND) ? roll_tilt_reg
                                                                 : pitch_tilt_reg;
        gyro = ACC_W'(est_sel) + step;
        mix = (MUL_PW'(acc_sel) <<< 16) + mul_p + 43'sd32768;
        blended = sat_ang(signed'(mix[MUL_PW-1:16]));

        // drop the output word once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // apply register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BLEND_GAIN:  gain_next = cfg_data;
                REG_ROLL_OFFSET: roll_off_next = cfg_data;
                REG_PITCH_OFF:   pitch_off_next = cfg_data;
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ax_next = accel_x;
                    ay_next = accel_y;
                    az_next = accel_z;
                    wr_next = rate_roll;
                    wp_next = rate_pitch;
                    us_next = (elapsed_us > DT_W'(DT_MAX_US)) ? US_W'(DT_MAX_US)
                                                              : US_W'(elapsed_us);
                    seed_next = seed;
                    state_next = S_RACC;
                    go_next = 1'b1;
                end
            end
            S_RACC:
            begin
                if (cordic_done)
                begin
                    roll_tilt_next = cordic_z;
                    if (seed_reg)
                    begin
                        roll_est_next = sat_ang(SAT_W'(cordic_z));
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SQA;
                        go_next = 1'b1;
                    end
                end
            end
            S_SQA:
            begin
                if (mul_done)
                begin
                    mag2_next = mul_p[31:0];
                    state_next = S_SQB;
                    go_next = 1'b1;
                end
            end
            S_SQB:
            begin
                if (mul_done)
                begin
                    mag2_next = mag2_reg + mul_p[31:0];
                    state_next = S_ROOT;
                    go_next = 1'b1;
                end
            end
            S_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = S_PACC;
                    go_next = 1'b1;
                end
            end
            S_PACC:
            begin
                if (cordic_done)
                begin
                    pitch_tilt_next = cordic_z;
                    state_next = S_RMUL;
                    go_next = 1'b1;
                end
            end
            S_RMUL, S_PMUL:
            begin
                if (mul_done)
                begin
                    neg_next = mul_p[MUL_PW-1];
                    mag_next = p_abs[33:0];
                    state_next = (state_reg == S_RMUL) ? S_RDIV : S_PDIV;
                    go_next = 1'b1;
                end
            end
            S_RDIV, S_PDIV:
            begin
                if (div_done)
                begin
                    diff_next = 25'(gyro) - 25'(acc_sel);
                    state_next = (state_reg == S_RDIV) ? S_RBLEND : S_PBLEND;
                    go_next = 1'b1;
                end
            end
            S_RBLEND:
            begin
                if (mul_done)
                begin
                    roll_est_next = blended;
                    state_next = S_PMUL;
                    go_next = 1'b1;
                end
            end
            S_PBLEND:
            begin
                if (mul_done)
                begin
                    pitch_est_next = blended;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    roll_out_next = roll_est_reg;
                    pitch_out_next = pitch_est_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            roll_out_reg <= '0;
            pitch_out_reg <= '0;
            gain_reg <= GAIN_RESET;
            roll_off_reg <= '0;
            pitch_off_reg <= '0;
            roll_est_reg <= '0;
            pitch_est_reg <= '0;
            ax_reg <= '0;
            ay_reg <= '0;
            az_reg <= '0;
            wr_reg <= '0;
            wp_reg <= '0;
            us_reg <= '0;
            seed_reg <= 1'b0;
            mag2_reg <= '0;
            roll_tilt_reg <= '0;
            pitch_tilt_reg <= '0;
            neg_reg <= 1'b0;
            mag_reg <= '0;
            diff_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg <= go_next;
            out_valid_reg <= out_valid_next;
            roll_out_reg <= roll_out_next;
            pitch_out_reg <= pitch_out_next;
            gain_reg <= gain_next;
            roll_off_reg <= roll_off_next;
            pitch_off_reg <= pitch_off_next;
            roll_est_reg <= roll_est_next;
            pitch_est_reg <= pitch_est_next;
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            az_reg <= az_next;
            wr_reg <= wr_next;
            wp_reg <= wp_next;
            us_reg <= us_next;
            seed_reg <= seed_next;
            mag2_reg <= mag2_next;
            roll_tilt_reg <= roll_tilt_next;
            pitch_tilt_reg <= pitch_tilt_next;
            neg_reg <= neg_next;
            mag_reg <= mag_next;
            diff_reg <= diff_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign roll_angle = roll_out_reg;
    assign pitch_angle = pitch_out_reg;

endmodule

@@ hdl/cifu_checker.sv @@
// Port-level checks for the complementary filter, bound to the top level.
module cifu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [22:0] roll_angle,
    input logic signed [22:0] pitch_angle
);

    // a waiting input word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input word withdrawn before accept");

    // a stalled output word holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roll_angle) && $stable(pitch_angle))
        else $error("output word changed while stalled");

    // an accepted word keeps the unit busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after accept");

    // a new result appears only while a word is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared with no word in work");

endmodule

bind imu_complementary_filter_unit cifu_checker u_cifu_checker (.*);
